/* rtl/core/magnitudes_to_normalized_stokes_top_defines.svh */
// Assertion macros for the magnitudes_to_normalized_stokes block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef MAGNITUDES_TO_NORMALIZED_STOKES_TOP_DEFINES_SVH
`define MAGNITUDES_TO_NORMALIZED_STOKES_TOP_DEFINES_SVH

// same-cycle implication
`define MTNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mtns_pkg.sv */
// Shared types and constants for the magnitudes to normalized Stokes block.
// No dependencies.
`timescale 1ns / 1ps

package mtns_pkg;

  localparam int P_W     = 32;  // polynomial accumulator, Q30
  localparam int X_W     = 30;  // exponent fraction, Q30
  localparam int FLUX_W  = 42;  // flux in Q30, up to 2^41
  localparam int SUM_W   = 44;  // sum of four fluxes
  localparam int Q_W     = 23;  // quotient bits, result <= 6553600
  localparam int OUT_W   = 24;  // signed Q8.16 result
  localparam int NUM_W   = 65;  // mag * 6553600 + sum/2
  localparam int CNT_W   = $clog2(Q_W);
  localparam int HORN_N  = 9;   // coefficient count incl. leading 1.0

  // 0.4 * log2(10) in Q30
  localparam logic [30:0] EXP_SCALE = 31'd1426757253;

  localparam logic [FLUX_W-1:0] FLUX_ONE = FLUX_W'(64'd1073741824);
  localparam logic [SUM_W-1:0]  SUM_INIT = SUM_W'(64'd1073741824);

  // Taylor coefficients of 2^x in Q30, index 0 is the constant term
  localparam logic [P_W-1:0] POW2_COEF [0:HORN_N-1] = '{
    32'd1073741824, 32'd744261118, 32'd257941247, 32'd59597083,
    32'd10327388,   32'd1431680,   32'd165394,    32'd16378,
    32'd1419
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_EXPO,
    ST_SPLIT,
    ST_HORN,
    ST_SCALE,
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_DONE
  } seq_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MAG,
    DV_NUM,
    DV_STEP,
    DV_DONE
  } div_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic in_stall;
    logic horner;
    logic ld_diff;
    logic ld_t;
    logic ld_split;
    logic ld_horn;
    logic ld_scale;
    logic div_start;
    logic div_sel_y;
    logic ld_px;
    logic ld_py;
    logic ld_out;
  } seq_ctl_t;

endpackage

/* rtl/core/mtns_div.sv */
// Iterative normalizer: round(|a-b| * 6553600 / sum), signed by a-b.
// Restoring division, one quotient bit per cycle. Uses mtns_pkg.
`timescale 1ns / 1ps

module mtns_div import mtns_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FLUX_W-1:0] a_i,
  input  logic [FLUX_W-1:0] b_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic [OUT_W-1:0]  res_o,
  output div_stat_t         stat_o
);

  localparam int M100_W = FLUX_W + 7;

  div_state_e          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                neg_q;
  logic [FLUX_W-1:0]   mag_q;
  logic [SUM_W-1:0]    rem_q;
  logic [Q_W-1:0]      lo_q;

  logic [M100_W-1:0]   m_ext, mag100;
  logic [NUM_W-1:0]    num;
  logic [SUM_W:0]      trial, trial_sub;
  logic                ge;
  logic [OUT_W-1:0]    q_ext;

  // 6553600 = 100 << 16, 100 = 64 + 32 + 4
  assign m_ext  = M100_W'(mag_q);
  assign mag100 = (m_ext << 6) + (m_ext << 5) + (m_ext << 2);
  assign num    = {mag100, 16'b0} + NUM_W'(sum_i >> 1);

  assign trial     = {rem_q, lo_q[Q_W-1]};
  assign ge        = trial >= {1'b0, sum_i};
  assign trial_sub = trial - {1'b0, sum_i};

  assign q_ext = OUT_W'(lo_q);
  assign res_o = neg_q ? (~q_ext + OUT_W'(1)) : q_ext;

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (start_i) state_d = DV_MAG;
      DV_MAG:  state_d = DV_NUM;
      DV_NUM:  state_d = DV_STEP;
      DV_STEP: if (cnt_q == CNT_W'(Q_W - 1)) state_d = DV_DONE;
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q != DV_IDLE);
    stat_o.done = (state_q == DV_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DV_STEP) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          neg_q <= a_i < b_i;
          mag_q <= (a_i < b_i) ? (b_i - a_i) : (a_i - b_i);
        end
      end
      DV_NUM: begin
        rem_q <= SUM_W'(num[NUM_W-1:Q_W]);
        lo_q  <= num[Q_W-1:0];
      end
      DV_STEP: begin
        rem_q <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
        lo_q  <= {lo_q[Q_W-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/magnitudes_to_normalized_stokes_top.sv */
// Top level of the magnitudes to normalized Stokes block: group sequencer,
// shared multiplier for exponent and 2^x polynomial. Uses mtns_pkg, mtns_div.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: magnitude_i with in_valid_i / in_stall_o. Items come in
//   groups of four (x1, y1, x2, y2). The first three of a group are stored
//   and taken in one cycle each. The fourth starts the computation and
//   in_stall_o stays high until the result sits in the output register.
//   Output channel: pol_x_o, pol_y_o, clipped_o with out_valid_o / out_stall_i,
//   one item per group.
//   Processing of the fourth item: three fluxes, each by difference,
//   exponent multiply, split, eight Horner steps on the shared multiplier,
//   scale and sum, then two divisions on the restoring divider, then the
//   load of the output register.
//   Reset clears the group position, the sequencer and the output valid.
//   A stalled output item holds; a finished group waits in the last state
//   until the output register is free, keeping the input stalled.
//   Differences beyond +-8.0 magnitudes are clamped and flag clipped_o.
//
module magnitudes_to_normalized_stokes_top import mtns_pkg::*; #(
  parameter int MAG_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MAG_WIDTH-1:0] magnitude_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_W-1:0]     pol_x_o,
  output logic [OUT_W-1:0]     pol_y_o,
  output logic                 clipped_o
);

  localparam int DIFF_W = MAG_WIDTH + 1;
  localparam int D_W    = FRAC_BITS + 5;           // holds +-8.0
  localparam int CMP_W  = ((DIFF_W > D_W) ? DIFF_W : D_W) + 1;
  localparam int T_W    = D_W + 31;                // d * EXP_SCALE
  localparam int N_W    = T_W - FRAC_BITS - 30;    // integer part of exponent
  localparam int MA_W   = 33;
  localparam int MB_W   = 32;
  localparam int MP_W   = MA_W + MB_W;
  localparam int K_W    = $clog2(HORN_N);

  localparam logic signed [CMP_W-1:0] LIM_POS = CMP_W'(64'd8 << FRAC_BITS);
  localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;

  // --- state ---
  seq_state_e                state_q, state_d;
  seq_ctl_t                  ctl;
  logic [1:0]                gpos_q;
  logic [1:0]                idx_q;
  logic [K_W-1:0]            k_q;
  logic                      clip_q;
  logic                      out_valid_q;

  logic [MAG_WIDTH-1:0]      held_q [0:2];
  logic [MAG_WIDTH-1:0]      mag3_q;
  logic signed [D_W-1:0]     d_q;
  logic [T_W-1:0]            t_q;
  logic signed [N_W-1:0]     n_q;
  logic [X_W-1:0]            x_q;
  logic [P_W-1:0]            p_q;
  logic [FLUX_W-1:0]         f1_q, f2_q, f3_q;
  logic [SUM_W-1:0]          sum_q;
  logic [OUT_W-1:0]          px_q, py_q;
  logic [OUT_W-1:0]          pol_x_q, pol_y_q;
  logic                      clipped_q;

  // --- datapath nets ---
  logic                      in_acc;
  logic                      out_free;
  logic [MAG_WIDTH-1:0]      sel_m;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [CMP_W-1:0]   diff_c, diff_s;
  logic                      sat;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    mul_p;
  logic [FLUX_W-1:0]         p_ext, flux;
  logic [N_W-1:0]            neg_n;
  logic [FLUX_W-1:0]         div_a, div_b;
  logic [OUT_W-1:0]          div_res;
  div_stat_t                 div_stat;

  assign in_acc   = in_valid_i && !ctl.in_stall;
  assign out_free = !out_valid_q || !out_stall_i;

  // magnitude difference against the group's first item, clamped to +-8.0
  always_comb begin
    case (idx_q)
      2'd0:    sel_m = held_q[1];
      2'd1:    sel_m = held_q[2];
      default: sel_m = mag3_q;
    endcase
    diff   = $signed({sel_m[MAG_WIDTH-1], sel_m})
           - $signed({held_q[0][MAG_WIDTH-1], held_q[0]});
    diff_c = CMP_W'(diff);
    sat    = 1'b1;
    if (diff_c > LIM_POS) begin
      diff_s = LIM_POS;
    end else if (diff_c < LIM_NEG) begin
      diff_s = LIM_NEG;
    end else begin
      diff_s = diff_c;
      sat    = 1'b0;
    end
  end

  // shared multiplier: d * 0.4*log2(10), or p * x in the Horner steps
  assign mul_a = ctl.horner ? $signed({1'b0, p_q}) : MA_W'(d_q);
  assign mul_b = ctl.horner ? $signed({2'b0, x_q}) : $signed({1'b0, EXP_SCALE});
  assign mul_p = mul_a * mul_b;

  // 2^n scaling, truncating on right shifts
  assign p_ext = FLUX_W'(p_q);
  assign neg_n = -n_q;
  assign flux  = n_q[N_W-1] ? (p_ext >> neg_n) : (p_ext << n_q);

  assign div_a = ctl.div_sel_y ? f1_q : FLUX_ONE;
  assign div_b = ctl.div_sel_y ? f3_q : f2_q;

  mtns_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .sum_i   (sum_q),
    .res_o   (div_res),
    .stat_o  (div_stat)
  );

  // --- sequencer: next state ---
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && gpos_q == 2'd3) state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_EXPO;
      ST_EXPO:   state_d = ST_SPLIT;
      ST_SPLIT:  state_d = ST_HORN;
      ST_HORN:   if (k_q == '0) state_d = ST_SCALE;
      ST_SCALE:  state_d = (idx_q == 2'd2) ? ST_DIV_X : ST_DIFF;
      ST_DIV_X:  state_d = ST_WAIT_X;
      ST_WAIT_X: if (div_stat.done) state_d = ST_DIV_Y;
      ST_DIV_Y:  state_d = ST_WAIT_Y;
      ST_WAIT_Y: if (div_stat.done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --- sequencer: controls ---
  always_comb begin
    ctl           = '0;
    ctl.in_stall  = (state_q != ST_IDLE);
    case (state_q)
      ST_DIFF:   ctl.ld_diff  = 1'b1;
      ST_EXPO:   ctl.ld_t     = 1'b1;
      ST_SPLIT:  ctl.ld_split = 1'b1;
      ST_HORN: begin
        ctl.horner  = 1'b1;
        ctl.ld_horn = 1'b1;
      end
      ST_SCALE:  ctl.ld_scale = 1'b1;
      ST_DIV_X:  ctl.div_start = 1'b1;
      ST_WAIT_X: ctl.ld_px = div_stat.done;
      ST_DIV_Y: begin
        ctl.div_start = 1'b1;
        ctl.div_sel_y = 1'b1;
      end
      ST_WAIT_Y: begin
        ctl.div_sel_y = 1'b1;
        ctl.ld_py     = div_stat.done;
      end
      ST_DONE:   ctl.ld_out = out_free;
      default: ;
    endcase
  end

  // --- control registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gpos_q      <= 2'd0;
      idx_q       <= 2'd0;
      k_q         <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        gpos_q <= gpos_q + 2'd1;
        if (gpos_q == 2'd3) begin
          idx_q  <= 2'd0;
          clip_q <= 1'b0;
        end
      end
      if (ctl.ld_diff && sat) clip_q <= 1'b1;
      if (ctl.ld_split) k_q <= K_W'(HORN_N - 2);
      if (ctl.ld_horn)  k_q <= k_q - K_W'(1);
      if (ctl.ld_scale) idx_q <= idx_q + 2'd1;
      if (ctl.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (gpos_q == 2'd3) begin
        mag3_q <= magnitude_i;
        sum_q  <= SUM_INIT;
      end else begin
        held_q[gpos_q] <= magnitude_i;
      end
    end
    if (ctl.ld_diff)  d_q <= D_W'(diff_s);
    if (ctl.ld_t)     t_q <= mul_p[T_W-1:0];
    if (ctl.ld_split) begin
      n_q <= $signed(t_q[T_W-1 -: N_W]);
      x_q <= t_q[FRAC_BITS+X_W-1 : FRAC_BITS];
      p_q <= POW2_COEF[HORN_N-1];
    end
    if (ctl.ld_horn) p_q <= POW2_COEF[k_q] + mul_p[X_W+P_W-1:X_W];
    if (ctl.ld_scale) begin
      sum_q <= sum_q + SUM_W'(flux);
      case (idx_q)
        2'd0:    f1_q <= flux;
        2'd1:    f2_q <= flux;
        default: f3_q <= flux;
      endcase
    end
    if (ctl.ld_px) px_q <= div_res;
    if (ctl.ld_py) py_q <= div_res;
    if (ctl.ld_out) begin
      pol_x_q   <= px_q;
      pol_y_q   <= py_q;
      clipped_q <= clip_q;
    end
  end

  assign in_stall_o  = ctl.in_stall;
  assign out_valid_o = out_valid_q;
  assign pol_x_o     = pol_x_q;
  assign pol_y_o     = pol_y_q;
  assign clipped_o   = clipped_q;

endmodule

/* rtl/core/mtns_chk.sv */
// Port checker for magnitudes_to_normalized_stokes_top, attached by bind.
// Uses the assertion macros of magnitudes_to_normalized_stokes_top_defines.svh.
`timescale 1ns / 1ps
`include "magnitudes_to_normalized_stokes_top_defines.svh"

module mtns_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] pol_x_o,
  input logic [23:0] pol_y_o,
  input logic        clipped_o
);

  // a stalled output item holds
  `MTNS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pol_x_o) && $stable(pol_y_o) && $stable(clipped_o), "stalled output item changed")

  // a new result only appears while the input side is held off
  `MTNS_ASSERT_IMP(a_new_while_busy, $rose(out_valid_o), $past(in_stall_o), "result without busy group")

  // results stay within +-100 percent
  `MTNS_ASSERT_IMP(a_px_range, out_valid_o, $signed(pol_x_o) >= -24'sd6553600 && $signed(pol_x_o) <= 24'sd6553600, "pol_x out of range")

  `MTNS_ASSERT_IMP(a_py_range, out_valid_o, $signed(pol_y_o) >= -24'sd6553600 && $signed(pol_y_o) <= 24'sd6553600, "pol_y out of range")

endmodule

bind magnitudes_to_normalized_stokes_top mtns_chk u_mtns_chk (.*);
